@@ design/sct_pkg.sv @@
// Shared constants, payload types and fixed-point helpers for the sine/cosine/tangent block.
package sct_pkg;

  // Default output fraction width and internal fraction width
  localparam int FRAC_BITS_DEF = 16;
  localparam int IFRAC = 30;

  // Q30 constants: pi, 2*pi, pi/2, 4/pi, 4/pi^2, 0.225
  localparam logic [63:0] PI_Q30     = 64'd3373259422;
  localparam logic [63:0] TWOPI_Q30  = 64'd6746518845;
  localparam logic [63:0] HALFPI_Q30 = 64'd1686629706;
  localparam logic [63:0] C1_Q30     = 64'd1367130546;
  localparam logic [63:0] C2_Q30     = 64'd435171165;
  localparam logic [63:0] CORR_Q30   = 64'd241591910;

  // Sine values (Q30, signed) and their magnitudes
  localparam int SW = 34;
  localparam int MW = 33;

  // Function select codes
  localparam logic [1:0] OP_SIN = 2'd0;
  localparam logic [1:0] OP_COS = 2'd1;
  localparam logic [1:0] OP_TAN = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] angle;
  } arg_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               overflow;
  } res_t;

  // Side data carried along the divider cells
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic        czero;
    logic        neg;
  } meta_t;

  // Unsigned Q30 product, rounded to nearest
  function automatic logic [63:0] umul_q30(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return (p + 64'(1 << (IFRAC - 1))) >> IFRAC;
  endfunction

endpackage

@@ design/fast_sin_cos_tan_approx.sv @@
// Fast sine/cosine/tangent of a fixed-point angle.
// Pipeline: input register, 30 - FRAC_BITS turn-removal cells, the sine pipeline (5),
// divider setup, MW + FRAC_BITS + 1 divider cells and the output register.
// Throughput: one transfer per cycle; the whole chain holds while a result is stalled.
// Reset clears only the valid bits; data registers are not reset.
module fast_sin_cos_tan_approx import sct_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic arg_valid,
  output logic arg_stall,
  input  arg_t arg,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int SH  = IFRAC - FRAC_BITS;
  localparam int XW  = 63 - FRAC_BITS;
  localparam int NT  = 30 - FRAC_BITS;
  localparam int DW  = MW + FRAC_BITS + 1;
  localparam int PRE = 1 + NT + 5;
  localparam int VL  = PRE + 1 + DW;

  logic en;
  logic [VL-1:0] vpipe;
  logic [1:0]    oppipe [PRE];

  logic [XW-1:0] ts_mag [NT+1];
  logic          ts_neg [NT+1];
  logic [XW-1:0] tc_mag [NT+1];
  logic          tc_neg [NT+1];

  logic signed [SW-1:0] s_q30;
  logic signed [SW-1:0] c_q30;

  logic [MW-1:0] dv_cm  [DW+1];
  logic [MW-1:0] dv_rem [DW+1];
  logic [DW-1:0] dv_num [DW+1];
  meta_t         dv_meta[DW+1];

  logic signed [63:0] xs;
  logic signed [63:0] xc;

  // Rounded Q30 to output format
  function automatic logic [31:0] to_out(input logic signed [SW-1:0] v);
    logic [63:0] mg;
    logic [63:0] r;
    mg = v[SW-1] ? 64'(-64'(v)) : 64'(v);
    r  = (mg + 64'(1 << (SH - 1))) >> SH;
    return v[SW-1] ? 32'(-r) : 32'(r);
  endfunction

  // Whole chain advances unless the output holds a stalled result
  assign en        = !(res_valid && res_stall);
  assign arg_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe     <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vpipe     <= {vpipe[VL-2:0], arg_valid};
      res_valid <= vpipe[VL-1];
    end
  end

  // Widen to Q30, form sine and cosine angles
  assign xs = 64'(arg.angle) <<< SH;
  assign xc = xs + $signed(HALFPI_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      ts_neg[0] <= xs[63];
      ts_mag[0] <= xs[63] ? XW'(-xs) : XW'(xs);
      tc_neg[0] <= xc[63];
      tc_mag[0] <= xc[63] ? XW'(-xc) : XW'(xc);
      oppipe[0] <= arg.op;
      for (int i = 1; i < PRE; i++) begin
        oppipe[i] <= oppipe[i-1];
      end
    end
  end

  // Turn removal chains, largest multiple first
  for (genvar k = 0; k < NT; k++) begin : g_turn
    sct_turn_cell #(.XW(XW), .K(NT - 1 - k)) u_sin (
      .clk(clk), .en(en),
      .mag_in(ts_mag[k]), .neg_in(ts_neg[k]),
      .mag(ts_mag[k+1]), .neg(ts_neg[k+1])
    );
    sct_turn_cell #(.XW(XW), .K(NT - 1 - k)) u_cos (
      .clk(clk), .en(en),
      .mag_in(tc_mag[k]), .neg_in(tc_neg[k]),
      .mag(tc_mag[k+1]), .neg(tc_neg[k+1])
    );
  end

  sct_poly u_poly_sin (
    .clk(clk), .en(en), .rin(ts_mag[NT][MW-1:0]), .neg_in(ts_neg[NT]), .s(s_q30)
  );
  sct_poly u_poly_cos (
    .clk(clk), .en(en), .rin(tc_mag[NT][MW-1:0]), .neg_in(tc_neg[NT]), .s(c_q30)
  );

  // Divider setup and sine/cosine results
  always_ff @(posedge clk) begin
    logic [MW-1:0] sm;
    logic [MW-1:0] cmv;
    sm  = s_q30[SW-1] ? MW'(-s_q30) : MW'(s_q30);
    cmv = c_q30[SW-1] ? MW'(-c_q30) : MW'(c_q30);
    if (en) begin
      dv_cm[0]  <= cmv;
      dv_rem[0] <= '0;
      dv_num[0] <= (DW'(sm) << FRAC_BITS) + DW'(cmv >> 1);
      dv_meta[0].op    <= oppipe[PRE-1];
      dv_meta[0].czero <= (c_q30 == '0);
      dv_meta[0].neg   <= s_q30[SW-1] != c_q30[SW-1];
      case (oppipe[PRE-1])
        OP_SIN:  dv_meta[0].value <= to_out(s_q30);
        OP_COS:  dv_meta[0].value <= to_out(c_q30);
        default: dv_meta[0].value <= '0;
      endcase
    end
  end

  // Division chain
  for (genvar j = 0; j < DW; j++) begin : g_div
    sct_div_cell #(.DW(DW)) u_cell (
      .clk(clk), .en(en),
      .cm_in(dv_cm[j]), .rem_in(dv_rem[j]), .num_in(dv_num[j]), .meta_in(dv_meta[j]),
      .cm(dv_cm[j+1]), .rem(dv_rem[j+1]), .num(dv_num[j+1]), .meta(dv_meta[j+1])
    );
  end

  // Output register with tangent saturation
  always_ff @(posedge clk) begin
    logic [63:0] q;
    meta_t       mt;
    q  = 64'(dv_num[DW]);
    mt = dv_meta[DW];
    if (en) begin
      if (mt.op == OP_TAN) begin
        if (mt.czero) begin
          res.value    <= 32'sh7FFFFFFF;
          res.overflow <= 1'b1;
        end else if (!mt.neg && q > 64'h7FFFFFFF) begin
          res.value    <= 32'sh7FFFFFFF;
          res.overflow <= 1'b1;
        end else if (mt.neg && q > 64'h80000000) begin
          res.value    <= 32'sh80000000;
          res.overflow <= 1'b1;
        end else begin
          res.value    <= mt.neg ? 32'(-q) : 32'(q);
          res.overflow <= 1'b0;
        end
      end else begin
        res.value    <= mt.value;
        res.overflow <= 1'b0;
      end
    end
  end

endmodule

@@ design/sct_turn_cell.sv @@
// One turn-removal cell: conditionally subtracts a scaled multiple of 2*pi.
module sct_turn_cell import sct_pkg::*; #(
  parameter int XW = 47,
  parameter int K  = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] mag_in,
  input  logic          neg_in,
  output logic [XW-1:0] mag,
  output logic          neg
);

  localparam logic [63:0] STEP = TWOPI_Q30 << K;

  logic [63:0] wide;
  assign wide = 64'(mag_in);

  // Compare and subtract, hand result to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      mag <= (wide >= STEP) ? XW'(wide - STEP) : mag_in;
      neg <= neg_in;
    end
  end

endmodule

@@ design/sct_poly.sv @@
// Five-stage fold and parabolic sine evaluation on a reduced angle.
module sct_poly import sct_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MW-1:0]        rin,
  input  logic                 neg_in,
  output logic signed [SW-1:0] s
);

  logic [31:0]          m0;
  logic                 n0;
  logic [31:0]          a1;
  logic [33:0]          mm1;
  logic                 n1;
  logic signed [SW-1:0] p2;
  logic signed [SW-1:0] p3;
  logic [MW-1:0]        ppm3;

  logic [63:0]        r64;
  logic               big;
  logic signed [63:0] pd;
  logic signed [63:0] pv;
  logic signed [63:0] p2w;
  logic [63:0]        pm;
  logic signed [63:0] p3w;
  logic signed [63:0] pp;
  logic signed [63:0] d;
  logic [63:0]        dm;
  logic [63:0]        cr;
  logic signed [63:0] corr;

  // Fold into [-pi, pi]
  assign r64 = 64'(rin);
  assign big = r64 > PI_Q30;

  // Parabola, sign applied
  assign pd = $signed(64'(a1)) - $signed(umul_q30(C2_Q30, 64'(mm1)));
  assign pv = n1 ? -pd : pd;

  // Square of the parabola
  assign p2w = 64'(p2);
  assign pm  = p2w[63] ? 64'(-p2w) : 64'(p2w);

  // Refinement term
  assign p3w  = 64'(p3);
  assign pp   = p3w[63] ? -$signed(64'(ppm3)) : $signed(64'(ppm3));
  assign d    = pp - p3w;
  assign dm   = d[63] ? 64'(-d) : 64'(d);
  assign cr   = umul_q30(dm, CORR_Q30);
  assign corr = d[63] ? -$signed(cr) : $signed(cr);

  always_ff @(posedge clk) begin
    if (en) begin
      m0   <= big ? 32'(TWOPI_Q30 - r64) : 32'(r64);
      n0   <= neg_in ^ big;
      a1   <= 32'(umul_q30(C1_Q30, 64'(m0)));
      mm1  <= 34'(umul_q30(64'(m0), 64'(m0)));
      n1   <= n0;
      p2   <= SW'(pv);
      ppm3 <= MW'(umul_q30(pm, pm));
      p3   <= p2;
      s    <= SW'(p3w + corr);
    end
  end

endmodule

@@ design/sct_div_cell.sv @@
// One restoring-division cell: produces one quotient bit per cycle while en is high.
module sct_div_cell import sct_pkg::*; #(
  parameter int DW = 50
) (
  input  logic          clk,
  input  logic          en,
  input  logic [MW-1:0] cm_in,
  input  logic [MW-1:0] rem_in,
  input  logic [DW-1:0] num_in,
  input  meta_t         meta_in,
  output logic [MW-1:0] cm,
  output logic [MW-1:0] rem,
  output logic [DW-1:0] num,
  output meta_t         meta
);

  logic [MW:0] r2;
  logic [MW:0] diff;
  logic        ge;

  // Shift in next dividend bit, trial subtract
  assign r2   = {rem_in, num_in[DW-1]};
  assign diff = r2 - {1'b0, cm_in};
  assign ge   = r2 >= {1'b0, cm_in};

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= ge ? diff[MW-1:0] : r2[MW-1:0];
      num  <= {num_in[DW-2:0], ge};
      cm   <= cm_in;
      meta <= meta_in;
    end
  end

endmodule
